/* hdl/spa_pkg.sv */
// Shared definitions for the slot pool allocator.
// Port widths, request and status codes, and the sequencer state type.
// No dependencies.
package spa_pkg;

  // Default pool size; the top level takes it as a parameter
  localparam int POOL_SLOTS_DEF = 1024;

  // Fixed port field widths
  localparam int SLOT_W   = 10;
  localparam int LIMIT_W  = 11;
  localparam int LIVE_W   = 11;
  localparam int STATUS_W = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

  // Request type codes
  localparam logic REQ_ACQUIRE = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_NOT_HELD  = 2'd2
  } status_t;

  // Request sequencer: capture, memory read, execute
  typedef enum logic [1:0] {
    CS_IDLE,
    CS_READ,
    CS_EXEC
  } ctrl_state_t;

endpackage

/* hdl/spa_ram.sv */
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Used for the free stack and for the occupancy map. No dependencies.
module spa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hdl/slot_pool_allocator_unit.sv */
// Slot pool allocator: LIFO free stack with a high-water mark for fresh slots.
// Depends on spa_pkg and spa_ram (free stack and occupancy map).
//
//   channel   handshake            payload
//   request   start / busy         req_type, slot_in
//   result    done (one cycle)     slot_out, status, live_slots
//   config    cfg_we               cfg_data (slot_limit)
//
// A request passes through capture, memory read, execute and write back;
// done pulses in the cycle after execute, and busy is low again in that cycle.
// No new request is accepted while busy is high; the memory read state is
// needed because the stack and occupancy memories have registered read data.
// Synchronous reset clears counters and sequencer; memories are not cleared.
// Results cannot be stalled: each is shown for exactly one cycle.
module slot_pool_allocator_unit
  import spa_pkg::*;
#(
  parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                req_type,
  input  logic [SLOT_W-1:0]   slot_in,
  output logic                done,
  output logic [SLOT_W-1:0]   slot_out,
  output logic [STATUS_W-1:0] status,
  output logic [LIVE_W-1:0]   live_slots,
  input  logic                cfg_we,
  input  logic [LIMIT_W-1:0]  cfg_data
);

  localparam int AW = $clog2(POOL_SLOTS);
  localparam int NW = $clog2(POOL_SLOTS + 1);
  localparam int XW = (NW > LIMIT_W) ? NW : LIMIT_W;
  localparam int GW = (AW > SLOT_W) ? AW : SLOT_W;
  localparam int LW = (NW > LIVE_W) ? NW : LIVE_W;
  localparam logic [XW-1:0] POOL_X = XW'(POOL_SLOTS);

  ctrl_state_t state, state_next;

  logic [LIMIT_W-1:0] slot_limit;
  logic               req_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [NW-1:0]      stack_depth, stack_depth_next;
  logic [NW-1:0]      high_water, high_water_next;
  logic [NW-1:0]      live_count, live_count_next;

  logic [AW-1:0]      stack_rdata, stack_waddr, stack_raddr;
  logic               stack_we;
  logic               occ_rdata, occ_wdata, occ_we;
  logic [AW-1:0]      occ_waddr, occ_raddr;

  logic [XW-1:0]      slot_x, usable_x, depth_x, hw_x;
  logic [AW-1:0]      grant;
  logic [GW-1:0]      grant_x;
  logic [LW-1:0]      live_x;
  status_t            res_status;
  logic               accept;

  assign busy   = (state != CS_IDLE);
  assign accept = start && !busy;

  // Widened views for compares
  assign slot_x   = XW'(slot_q);
  assign depth_x  = XW'(stack_depth);
  assign hw_x     = XW'(high_water);
  assign usable_x = (XW'(slot_limit) > POOL_X) ? POOL_X : XW'(slot_limit);

  // Memory read addresses: top of stack and the slot to release
  assign stack_raddr = AW'(stack_depth - NW'(1));
  assign occ_raddr   = slot_x[AW-1:0];

  spa_ram #(.WIDTH(AW), .DEPTH(POOL_SLOTS)) u_free_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (slot_x[AW-1:0]),
    .raddr (stack_raddr),
    .rdata (stack_rdata)
  );

  spa_ram #(.WIDTH(1), .DEPTH(POOL_SLOTS)) u_occ_map (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_waddr),
    .wdata (occ_wdata),
    .raddr (occ_raddr),
    .rdata (occ_rdata)
  );

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decide the request and the write-back
  always_comb begin
    state_next       = state;
    stack_depth_next = stack_depth;
    high_water_next  = high_water;
    live_count_next  = live_count;
    stack_we         = 1'b0;
    stack_waddr      = stack_depth[AW-1:0];
    occ_we           = 1'b0;
    occ_waddr        = slot_x[AW-1:0];
    occ_wdata        = 1'b0;
    grant            = '0;
    res_status       = ST_OK;
    case (state)
      CS_IDLE: begin
        if (accept) begin
          state_next = CS_READ;
        end
      end
      CS_READ: begin
        state_next = CS_EXEC;
      end
      CS_EXEC: begin
        state_next = CS_IDLE;
        if (req_q == REQ_ACQUIRE) begin
          if (stack_depth != '0) begin
            grant            = stack_rdata;
            stack_depth_next = stack_depth - NW'(1);
          end else if (hw_x < usable_x) begin
            grant           = high_water[AW-1:0];
            high_water_next = high_water + NW'(1);
          end else begin
            res_status = ST_EXHAUSTED;
          end
          if (res_status == ST_OK) begin
            occ_we          = 1'b1;
            occ_waddr       = grant;
            occ_wdata       = 1'b1;
            live_count_next = live_count + NW'(1);
          end
        end else begin
          if (slot_x >= hw_x || slot_x >= POOL_X || !occ_rdata || depth_x >= POOL_X) begin
            res_status = ST_NOT_HELD;
          end else begin
            occ_we           = 1'b1;
            stack_we         = 1'b1;
            stack_depth_next = stack_depth + NW'(1);
            if (live_count != '0) begin
              live_count_next = live_count - NW'(1);
            end
          end
        end
      end
      default: begin
        state_next = CS_IDLE;
      end
    endcase
  end

  assign grant_x = GW'(grant);
  assign live_x  = LW'(live_count_next);

  // Advance counters and the limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_depth <= '0;
      high_water  <= '0;
      live_count  <= '0;
      slot_limit  <= LIMIT_RESET;
      done        <= 1'b0;
    end else begin
      stack_depth <= stack_depth_next;
      high_water  <= high_water_next;
      live_count  <= live_count_next;
      done        <= (state == CS_EXEC);
      if (cfg_we) begin
        slot_limit <= cfg_data;
      end
    end
  end

  // Capture the request and the result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= req_type;
      slot_q <= slot_in;
    end
    if (state == CS_EXEC) begin
      slot_out   <= grant_x[SLOT_W-1:0];
      status     <= res_status;
      live_slots <= live_x[LIVE_W-1:0];
    end
  end

`ifndef SYNTH
  // Every slot below the mark is either held or on the free stack
  a_balance: assert property (@(posedge clk) disable iff (rst)
    (XW'(stack_depth) + XW'(live_count)) == hw_x)
    else $error("stack depth plus live count differs from high-water mark");

  a_mark_bound: assert property (@(posedge clk) disable iff (rst)
    hw_x <= POOL_X)
    else $error("high-water mark beyond pool size");

  a_done_follows_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == CS_EXEC))
    else $error("result strobe without an executed request");

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == CS_READ))
    else $error("accepted request did not start a memory read");
`endif

endmodule
